// File: hw/rtl/matrix3_inverse_macros.svh
// assertion macros for the matrix3_inverse checker
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

// checked outside reset
`define M3I_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define M3I_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hw/rtl/m3i_pkg.sv
// shared types and constants of the 3x3 matrix inverse
package m3i_pkg;

    localparam int N_EL   = 9;
    localparam int W_EL   = 32;
    localparam int W_COF  = 64;
    localparam int W_PLO  = 65;
    localparam int W_TERM = 97;
    localparam int W_DET  = 99;
    localparam int W_DMAG = 98;
    localparam int W_THR  = 16;
    localparam int N_STEP = 32;
    localparam int W_DATA = N_EL * W_EL;

    typedef logic signed [W_COF-1:0]      t_cof;
    typedef logic [N_EL-1:0][W_EL-1:0]    t_mat;
    typedef logic [3:0]                   t_idx;

    typedef struct packed {
        logic [W_EL-1:0] q;
        logic            ovf;
        logic            neg;
    } t_lane_res;

    localparam logic [W_THR-1:0] THR_RESET = 16'd7;
    localparam logic [W_EL-1:0]  SAT_POS   = 32'h7fff_ffff;
    localparam logic [W_EL-1:0]  SAT_NEG   = 32'h8000_0000;

    // cofactor k = e[A]*e[B] - e[C]*e[D]
    localparam t_idx COF_A [N_EL] = '{4'd4, 4'd7, 4'd1, 4'd5, 4'd8, 4'd2, 4'd3, 4'd6, 4'd0};
    localparam t_idx COF_B [N_EL] = '{4'd8, 4'd2, 4'd5, 4'd6, 4'd0, 4'd3, 4'd7, 4'd1, 4'd4};
    localparam t_idx COF_C [N_EL] = '{4'd7, 4'd1, 4'd4, 4'd8, 4'd2, 4'd5, 4'd6, 4'd0, 4'd3};
    localparam t_idx COF_D [N_EL] = '{4'd5, 4'd8, 4'd2, 4'd3, 4'd6, 4'd0, 4'd4, 4'd7, 4'd1};

endpackage

// File: hw/rtl/m3i_div_lane.sv
// one division lane: pipelined restoring divide of (|cofactor| << 2F) by |det|
module m3i_div_lane import m3i_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [W_COF-1:0]  i_cmag,
    input  logic              i_neg,
    input  logic [W_DMAG-1:0] i_dmag,
    output t_lane_res         o_res
);

    localparam int SHIFT = 2 * FRAC_BITS;
    localparam int NW    = W_COF + SHIFT;
    localparam int CW    = W_DMAG + W_EL;

    logic [NW-1:0]     w_num;
    logic              w_ovf;
    logic [W_DMAG-1:0] w_rem0;

    logic [W_DMAG-1:0] r_rem [0:N_STEP];
    logic [W_DMAG-1:0] r_d   [0:N_STEP];
    logic [W_EL-1:0]   r_low [0:N_STEP];
    logic [W_EL-1:0]   r_q   [0:N_STEP];
    logic              r_ovf [0:N_STEP];
    logic              r_neg [0:N_STEP];

    assign w_num  = {i_cmag, {SHIFT{1'b0}}};
    // quotient needs more than 32 bits
    assign w_ovf  = {{(CW-NW){1'b0}}, w_num} >= {i_dmag, {W_EL{1'b0}}};
    assign w_rem0 = {{(W_DMAG-(NW-W_EL)){1'b0}}, w_num[NW-1:W_EL]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_rem0;
            r_d[0]   <= i_dmag;
            r_low[0] <= w_num[W_EL-1:0];
            r_q[0]   <= '0;
            r_ovf[0] <= w_ovf;
            r_neg[0] <= i_neg;
        end
    end

    for (genvar s = 1; s <= N_STEP; s++) begin : g_step
        logic [W_DMAG:0] w_try;
        logic [W_DMAG:0] w_diff;
        logic            w_ge;

        assign w_try  = {r_rem[s-1], r_low[s-1][W_EL-1]};
        assign w_ge   = w_try >= {1'b0, r_d[s-1]};
        assign w_diff = w_try - {1'b0, r_d[s-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? w_diff[W_DMAG-1:0] : w_try[W_DMAG-1:0];
                r_d[s]   <= r_d[s-1];
                r_low[s] <= {r_low[s-1][W_EL-2:0], 1'b0};
                r_q[s]   <= {r_q[s-1][W_EL-2:0], w_ge};
                r_ovf[s] <= r_ovf[s-1];
                r_neg[s] <= r_neg[s-1];
            end
        end
    end

    assign o_res = '{q: r_q[N_STEP], ovf: r_ovf[N_STEP], neg: r_neg[N_STEP]};

endmodule

// File: hw/rtl/m3i_merge.sv
// merge of the nine lanes: sign, saturation and singular bypass
module m3i_merge import m3i_pkg::*; (
    input  t_lane_res i_res [N_EL],
    input  t_mat      i_mat,
    input  logic      i_sing,
    output t_mat      o_mat
);

    always_comb begin
        for (int k = 0; k < N_EL; k++) begin
            if (i_sing) begin
                o_mat[k] = i_mat[k];
            end else if (i_res[k].neg) begin
                if (i_res[k].ovf || (i_res[k].q > SAT_NEG)) begin
                    o_mat[k] = SAT_NEG;
                end else begin
                    o_mat[k] = -i_res[k].q;
                end
            end else begin
                if (i_res[k].ovf || i_res[k].q[W_EL-1]) begin
                    o_mat[k] = SAT_POS;
                end else begin
                    o_mat[k] = i_res[k].q;
                end
            end
        end
    end

endmodule

// File: hw/rtl/matrix3_inverse.sv
// 3x3 fixed-point matrix inverse by the adjugate method, top level
//
// slave stream takes one matrix per request: nine signed elements, row-major,
// element 0 in the lowest 32 bits of tdata. master stream returns the inverse
// in the same order; tuser is set when the determinant counts as zero, and
// then the input elements come back unchanged
// throughput: one matrix per cycle while the skid is empty; each of the nine
// division lanes, one element each, is a 32-stage pipeline taking one quotient
// bit per stage; the front end is seven stages: input register, products,
// cofactors, split determinant products, terms, determinant sum, magnitudes
// a skid register sits at the output: on a receiver stall the result moves
// into it while the pipeline still advances, then the pipeline holds until the
// skid drains; tready is low only while the skid is full
// reset (synchronous, active low) empties the pipeline and skid and loads the
// threshold with its default; outside reset the threshold write port is taken at
// any edge with the write enable high, meant to be used while the block is idle
module matrix3_inverse import m3i_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [W_DATA-1:0] i_s_axis_tdata,   // in_e0 .. in_e8, 32 bits each
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [W_DATA-1:0] o_m_axis_tdata,   // out_e0 .. out_e8, 32 bits each
    output logic [0:0]        o_m_axis_tuser,   // singular
    input  logic              i_cfg_we,
    input  logic [W_THR-1:0]  i_cfg_wdata       // singular_threshold
);

    localparam int SHIFT = 2 * FRAC_BITS;

    // control
    logic              w_en;
    logic [6:0]        r_vld;
    logic [N_STEP:0]   r_lvld;
    logic              r_ovld;
    logic              r_skid_vld;
    logic              n_skid_vld;
    logic [W_THR-1:0]  r_thr;

    // front end payload
    t_mat              r_e_a, r_e_b, r_e_c, r_e_d, r_e_e, r_e_f, r_e_g;
    t_cof              r_pa [N_EL];
    t_cof              r_pb [N_EL];
    t_cof              r_c  [N_EL];
    t_cof              r_c_d [N_EL];
    t_cof              r_c_e [N_EL];
    t_cof              r_c_f [N_EL];
    logic signed [W_COF-1:0] r_phi [3];
    logic signed [W_PLO-1:0] r_plo [3];
    logic [W_TERM-1:0] r_t [3];
    logic [W_DET-1:0]  r_det;
    logic [W_DET-1:0]  w_det_neg;
    logic [W_DMAG-1:0] r_dmag;
    logic              r_dneg;
    logic [W_COF-1:0]  r_cmag [N_EL];
    logic [N_EL-1:0]   r_cneg;

    // side band beside the lanes
    t_mat              r_sb_e    [0:N_STEP];
    logic              r_sb_sing [0:N_STEP];
    logic [W_DMAG-1:0] w_thr_sh;
    logic              w_sing;

    // lanes, merge, output
    t_lane_res         w_res [N_EL];
    t_mat              w_merge;
    t_mat              r_o_data;
    logic              r_o_sing;
    t_mat              r_skid_data;
    logic              r_skid_sing;

    // pipeline moves whenever the skid is empty
    assign w_en            = !r_skid_vld;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_lvld <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[5:0], i_s_axis_tvalid};
            r_lvld <= {r_lvld[N_STEP-1:0], r_vld[6]};
            r_ovld <= r_lvld[N_STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    assign w_det_neg = -r_det;

    // front end: cofactors and determinant
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_a <= i_s_axis_tdata;

            // the eighteen element products
            for (int k = 0; k < N_EL; k++) begin
                r_pa[k] <= $signed(r_e_a[COF_A[k]]) * $signed(r_e_a[COF_B[k]]);
                r_pb[k] <= $signed(r_e_a[COF_C[k]]) * $signed(r_e_a[COF_D[k]]);
            end
            r_e_b <= r_e_a;

            // cofactors wrap at 64 bits
            for (int k = 0; k < N_EL; k++) begin
                r_c[k] <= r_pa[k] - r_pb[k];
            end
            r_e_c <= r_e_b;

            // first column times first three cofactors, split into halves
            for (int j = 0; j < 3; j++) begin
                r_phi[j] <= $signed(r_e_c[4'(3*j)]) * $signed(r_c[j][W_COF-1:W_EL]);
                r_plo[j] <= $signed(r_e_c[4'(3*j)]) * $signed({1'b0, r_c[j][W_EL-1:0]});
            end
            r_c_d <= r_c;
            r_e_d <= r_e_c;

            for (int j = 0; j < 3; j++) begin
                r_t[j] <= {r_phi[j][W_COF-1], r_phi[j], {W_EL{1'b0}}}
                        + {{(W_TERM-W_PLO){r_plo[j][W_PLO-1]}}, r_plo[j]};
            end
            r_c_e <= r_c_d;
            r_e_e <= r_e_d;

            r_det <= {{2{r_t[0][W_TERM-1]}}, r_t[0]}
                   + {{2{r_t[1][W_TERM-1]}}, r_t[1]}
                   + {{2{r_t[2][W_TERM-1]}}, r_t[2]};
            r_c_f <= r_c_e;
            r_e_f <= r_e_e;

            // magnitudes and signs for the lanes
            r_dneg <= r_det[W_DET-1];
            r_dmag <= r_det[W_DET-1] ? w_det_neg[W_DMAG-1:0] : r_det[W_DMAG-1:0];
            for (int k = 0; k < N_EL; k++) begin
                r_cneg[k] <= r_c_f[k][W_COF-1];
                r_cmag[k] <= r_c_f[k][W_COF-1] ? W_COF'(-r_c_f[k]) : W_COF'(r_c_f[k]);
            end
            r_e_g <= r_e_f;
        end
    end

    // zero determinant is always singular, also with a zero threshold
    assign w_thr_sh = {{(W_DMAG-W_THR-SHIFT){1'b0}}, r_thr, {SHIFT{1'b0}}};
    assign w_sing   = (r_dmag < w_thr_sh) || (r_dmag == '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb_e[0]    <= r_e_g;
            r_sb_sing[0] <= w_sing;
            for (int s = 1; s <= N_STEP; s++) begin
                r_sb_e[s]    <= r_sb_e[s-1];
                r_sb_sing[s] <= r_sb_sing[s-1];
            end
        end
    end

    for (genvar k = 0; k < N_EL; k++) begin : g_lane
        m3i_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_cmag (r_cmag[k]),
            .i_neg  (r_cneg[k] ^ r_dneg),
            .i_dmag (r_dmag),
            .o_res  (w_res[k])
        );
    end

    m3i_merge u_merge (
        .i_res  (w_res),
        .i_mat  (r_sb_e[N_STEP]),
        .i_sing (r_sb_sing[N_STEP]),
        .o_mat  (w_merge)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_data <= w_merge;
            r_o_sing <= r_sb_sing[N_STEP];
        end
    end

    // skid: catches the output stage when the receiver stalls
    always_comb begin
        if (r_skid_vld) begin
            n_skid_vld = !i_m_axis_tready;
        end else begin
            n_skid_vld = r_ovld && !i_m_axis_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else begin
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_data <= r_o_data;
            r_skid_sing <= r_o_sing;
        end
    end

    assign o_m_axis_tvalid   = r_skid_vld || r_ovld;
    assign o_m_axis_tdata    = r_skid_vld ? r_skid_data : r_o_data;
    assign o_m_axis_tuser[0] = r_skid_vld ? r_skid_sing : r_o_sing;

endmodule

// File: hw/rtl/m3i_checker.sv
// port checker for matrix3_inverse and its bind
`include "matrix3_inverse_macros.svh"

module m3i_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [287:0] o_m_axis_tdata,
    input logic [0:0]   o_m_axis_tuser
);

    logic [7:0] r_cnt;
    logic [7:0] n_cnt;

    // requests taken but not yet delivered
    always_comb begin
        n_cnt = r_cnt;
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            n_cnt = n_cnt + 8'd1;
        end
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            n_cnt = n_cnt - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `M3I_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")
    `M3I_ASSERT(a_rdy_low, !o_s_axis_tready |-> o_m_axis_tvalid, "input blocked with no result waiting")
    `M3I_ASSERT(a_no_extra, o_m_axis_tvalid |-> r_cnt != 8'd0, "result without a request")
    `M3I_ASSERT_RST(a_reset, !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready, "reset did not empty the block")

endmodule

bind matrix3_inverse m3i_checker u_m3i_checker (.*);
